/* rtl/todb_pkg.sv */
`default_nettype none
package todb_pkg;

	// request codes
	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_RECALL = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic REG_DEPTH  = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	// register reset values
	localparam logic [5:0]  DEPTH_RESET  = 6'd32;
	localparam logic [15:0] WINDOW_RESET = 16'd100;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // request accepted: clear result fields, latch stamp
		logic push;     // write entry at head
		logic clear;    // empty the ring
		logic step;     // pop the entry under test
		logic done;     // result goes out next cycle
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_zero;
		logic future;   // entry under test lies ahead of the sample time
		logic last;     // entry under test is the only one held
	} status_t;

endpackage
`default_nettype wire

/* rtl/todb_ctrl.sv */
`default_nettype none
module todb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        req_type,
	input  wire todb_pkg::status_t status,
	output todb_pkg::cmd_t         cmd,
	output logic                   busy
);

	todb_pkg::state_t state_q;
	todb_pkg::state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= todb_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd = '0;
		busy = 1'b0;
		unique case (state_q)
			todb_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (req_type)
						todb_pkg::REQ_PUSH: begin
							cmd.push = 1'b1;
							cmd.done = 1'b1;
						end
						todb_pkg::REQ_RECALL: begin
							if (status.count_zero) begin
								cmd.done = 1'b1;
							end else begin
								state_next = todb_pkg::ST_WALK;
							end
						end
						todb_pkg::REQ_CLEAR: begin
							cmd.clear = 1'b1;
							cmd.done = 1'b1;
						end
						default: begin
							// unknown request answers without changing anything
							cmd.done = 1'b1;
						end
					endcase
				end
			end
			todb_pkg::ST_WALK: begin
				busy = 1'b1;
				if (status.future) begin
					cmd.done = 1'b1;
					state_next = todb_pkg::ST_IDLE;
				end else begin
					cmd.step = 1'b1;
					if (status.last) begin
						cmd.done = 1'b1;
						state_next = todb_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_next = todb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/todb_datapath.sv */
`default_nettype none
module todb_datapath #(
	parameter int DEPTH         = 32,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire todb_pkg::cmd_t           cmd,
	output todb_pkg::status_t             status,
	input  wire logic [31:0]              time_stamp,
	input  wire logic [PAYLOAD_WIDTH-1:0] payload_in,
	input  wire logic                     cfg_write,
	input  wire logic                     cfg_index,
	input  wire logic [15:0]              cfg_data,
	output logic                          done,
	output logic                          found,
	output logic [31:0]                   found_time,
	output logic [PAYLOAD_WIDTH-1:0]      payload_out,
	output logic [5:0]                    entries_held
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]              time_mem [DEPTH];
	logic [PAYLOAD_WIDTH-1:0] pay_mem  [DEPTH];

	logic [5:0]               depth_q;
	logic [15:0]              window_q;
	logic [PW-1:0]            oldest_q;
	logic [CW-1:0]            count_q;
	logic [31:0]              stamp_q;
	logic [31:0]              rd_time_q;
	logic [PAYLOAD_WIDTH-1:0] rd_pay_q;
	logic                     done_q;
	logic                     found_q;
	logic [31:0]              ftime_q;
	logic [PAYLOAD_WIDTH-1:0] fpay_q;

	logic [CW-1:0]            eff_depth;
	logic [CW-1:0]            oldest_plus;
	logic [PW-1:0]            oldest_inc;
	logic [CW:0]              head_sum;
	logic [PW-1:0]            head;
	logic [PW-1:0]            rd_addr;
	logic [31:0]              diff;
	logic                     in_window;

	// effective depth clamped to 1..DEPTH
	always_comb begin
		if (depth_q == 6'd0) begin
			eff_depth = CW'(1);
		end else if (int'(depth_q) > DEPTH) begin
			eff_depth = CW'(DEPTH);
		end else begin
			eff_depth = CW'(depth_q);
		end
	end

	// pointer arithmetic, all values stay below twice the depth
	always_comb begin
		oldest_plus = CW'(oldest_q) + CW'(1);
		oldest_inc  = (oldest_plus == eff_depth) ? '0 : PW'(oldest_plus);
		head_sum    = (CW + 1)'(oldest_q) + (CW + 1)'(count_q);
		if (head_sum >= (CW + 1)'(eff_depth)) begin
			head = PW'(head_sum - (CW + 1)'(eff_depth));
		end else begin
			head = PW'(head_sum);
		end
		rd_addr = cmd.step ? oldest_inc : oldest_q;
	end

	// age of the entry under test
	always_comb begin
		diff      = stamp_q - rd_time_q;
		in_window = diff < {16'd0, window_q};
	end

	assign status.count_zero = (count_q == '0);
	assign status.future     = diff[31];
	assign status.last       = (count_q == CW'(1));

	// ring storage
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			time_mem[head] <= time_stamp;
			pay_mem[head]  <= payload_in;
		end
		rd_time_q <= time_mem[rd_addr];
		rd_pay_q  <= pay_mem[rd_addr];
	end

	// configuration registers and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= todb_pkg::DEPTH_RESET;
			window_q <= todb_pkg::WINDOW_RESET;
			oldest_q <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cfg_write) begin
				unique case (cfg_index)
					todb_pkg::REG_DEPTH: begin
						depth_q  <= cfg_data[5:0];
						oldest_q <= '0;
						count_q  <= '0;
					end
					todb_pkg::REG_WINDOW: begin
						window_q <= cfg_data;
					end
					default: begin
						window_q <= window_q;
					end
				endcase
			end else if (cmd.push) begin
				if (count_q < eff_depth) begin
					count_q <= count_q + CW'(1);
				end else begin
					oldest_q <= oldest_inc;
				end
			end else if (cmd.clear) begin
				oldest_q <= '0;
				count_q  <= '0;
			end else if (cmd.step) begin
				oldest_q <= oldest_inc;
				count_q  <= count_q - CW'(1);
			end
			// result flag
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.step && in_window) begin
				found_q <= 1'b1;
			end
		end
	end

	// sample time and recalled entry
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stamp_q <= time_stamp;
			ftime_q <= '0;
			fpay_q  <= '0;
		end else if (cmd.step && in_window) begin
			ftime_q <= rd_time_q;
			fpay_q  <= rd_pay_q;
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign found_time   = ftime_q;
	assign payload_out  = fpay_q;
	assign entries_held = 6'(count_q);

endmodule
`default_nettype wire

/* rtl/timestamped_observation_delay_buffer.sv */
`default_nettype none
// Ring buffer of timestamped observations with time-matched recall. A request
// is taken when start is high and busy is low; its single result shows on the
// result ports, marked by done for one cycle, and cannot be held off. For push,
// clear and unknown requests done rises in the cycle after the request is taken
// and busy never rises. A recall walks the ring from the oldest entry at one
// entry per cycle, bounded by the single read port of the entry memory, with
// busy high while it walks; done follows the last entry examined (one popped,
// or one found in the future, if any). A recall on an empty buffer raises done
// in the cycle after the request. Writing the depth register empties the
// buffer.
module timestamped_observation_delay_buffer #(
	parameter int DEPTH         = 32,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               req_type,
	input  wire logic [31:0]              time_stamp,
	input  wire logic [PAYLOAD_WIDTH-1:0] payload_in,
	input  wire logic                     cfg_write,
	input  wire logic                     cfg_index,
	input  wire logic [15:0]              cfg_data,
	output logic                          done,
	output logic                          found,
	output logic [31:0]                   found_time,
	output logic [PAYLOAD_WIDTH-1:0]      payload_out,
	output logic [5:0]                    entries_held
);

	todb_pkg::cmd_t    cmd;
	todb_pkg::status_t status;

	// request sequencing
	todb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// ring storage, pointers and match logic
	todb_datapath #(
		.DEPTH         (DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.time_stamp   (time_stamp),
		.payload_in   (payload_in),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.found        (found),
		.found_time   (found_time),
		.payload_out  (payload_out),
		.entries_held (entries_held)
	);

endmodule
`default_nettype wire
